/* rtl/lna_pkg.sv */
// Package for the ASCII line assembler: codes, character constants,
// register indexes and the sequencer state type. No dependencies.
`default_nettype none

package lna_pkg;

	// default line store depth
	localparam int LINE_DEPTH_DEF = 64;

	// configuration port
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_LINE_CAP   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_READER_CAP = 2'd1;

	localparam logic [CFG_W-1:0] LINE_CAP_RST   = 7'd64;
	localparam logic [CFG_W-1:0] READER_CAP_RST = 7'd64;

	// input opcodes
	localparam logic OP_BYTE  = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	// result kinds
	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_ERR  = 1'b1;

	// character classes
	localparam logic [7:0] CHAR_MIN_PRINT = 8'd32;
	localparam logic [7:0] CHAR_MAX_PRINT = 8'd126;
	localparam logic [7:0] CHAR_NL        = 8'd10;
	localparam logic [7:0] CHAR_CR        = 8'd13;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ERR,
		ST_RD,
		ST_DATA
	} lna_state_t;

endpackage

`default_nettype wire

/* rtl/lna_line_ram.sv */
// Line store: one write port, one read port, registered read data.
// Depends on nothing; depth and address width come from the parent.
`default_nettype none

module lna_line_ram #(
	parameter int DEPTH  = 64,
	parameter int ADDR_W = 6
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [7:0]        wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [7:0]        rd_data
);

	logic [7:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

/* rtl/lna_ctrl.sv */
// Line assembler sequencer: byte classification, line length and drop
// state, configuration registers, line readout and the output word register.
// Depends on lna_pkg; drives the line store ports.
`default_nettype none

module lna_ctrl #(
	parameter int LINE_DEPTH = lna_pkg::LINE_DEPTH_DEF,
	parameter int LEN_W      = $clog2(LINE_DEPTH)
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// input words
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [7:0]                     s_tdata,
	input  wire logic                           s_tuser,
	// result words
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic      [7:0]                     m_tdata,
	output logic                                m_tuser,
	output logic                                m_tlast,
	// configuration writes
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [lna_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [lna_pkg::CFG_W-1:0]      cfg_data,
	// line store
	output logic                                wr_en,
	output logic      [LEN_W-1:0]               wr_addr,
	output logic      [7:0]                     wr_data,
	output logic                                rd_en,
	output logic      [LEN_W-1:0]               rd_addr,
	input  wire logic [7:0]                     rd_data
);

	// compare width: holds LINE_DEPTH and any 7-bit capacity plus one
	localparam int CMP_W = ((LEN_W > lna_pkg::CFG_W) ? LEN_W : lna_pkg::CFG_W) + 1;

	lna_pkg::lna_state_t state_q, state_d;

	logic [LEN_W-1:0]          len_q, len_d;
	logic                      drop_q, drop_d;
	logic [LEN_W-1:0]          rd_q, rd_d;
	logic [LEN_W-1:0]          last_q, last_d;
	logic [lna_pkg::CFG_W-1:0] line_cap_q, reader_cap_q;

	logic       ovalid_q;
	logic [7:0] ochar_q;
	logic       okind_q, olast_q;

	logic       accept, slot_free;
	logic       load, load_kind, load_last;
	logic [7:0] load_char;

	logic [CMP_W-1:0] len_inc, cap_line, cap_eff, depth_c, cap_rdr;
	logic             is_print, line_full, rdr_over;

	assign s_tready  = (state_q == lna_pkg::ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign slot_free = !ovalid_q || m_tready;
	assign cfg_ready = 1'b1;

	// capacity checks
	assign len_inc   = CMP_W'(len_q) + CMP_W'(1);
	assign cap_line  = CMP_W'(line_cap_q);
	assign depth_c   = CMP_W'(LINE_DEPTH);
	assign cap_eff   = (cap_line > depth_c) ? depth_c : cap_line;
	assign cap_rdr   = CMP_W'(reader_cap_q);
	assign line_full = (len_inc >= cap_eff);
	assign rdr_over  = (len_inc > cap_rdr);
	assign is_print  = (s_tdata >= lna_pkg::CHAR_MIN_PRINT) &&
	                   (s_tdata <= lna_pkg::CHAR_MAX_PRINT);

	assign wr_addr = len_q;
	assign wr_data = s_tdata;
	assign rd_addr = rd_q;

	// next state and control
	always_comb begin
		state_d   = state_q;
		len_d     = len_q;
		drop_d    = drop_q;
		rd_d      = rd_q;
		last_d    = last_q;
		wr_en     = 1'b0;
		rd_en     = 1'b0;
		load      = 1'b0;
		load_kind = lna_pkg::KIND_CHAR;
		load_char = 8'd0;
		load_last = 1'b0;
		unique case (state_q)
			lna_pkg::ST_IDLE: begin
				if (accept) begin
					priority if (s_tuser == lna_pkg::OP_CLEAR) begin
						len_d  = '0;
						drop_d = 1'b0;
					end else if (drop_q) begin
						if (s_tdata == lna_pkg::CHAR_NL) begin
							drop_d = 1'b0;
							len_d  = '0;
						end
					end else if (s_tdata == lna_pkg::CHAR_CR) begin
						// carriage return ignored
					end else if (s_tdata == lna_pkg::CHAR_NL) begin
						if (len_q != '0) begin
							len_d = '0;
							if (rdr_over) begin
								state_d = lna_pkg::ST_ERR;
							end else begin
								rd_d    = '0;
								last_d  = len_q - LEN_W'(1);
								state_d = lna_pkg::ST_RD;
							end
						end
					end else if (!is_print || line_full) begin
						drop_d  = 1'b1;
						len_d   = '0;
						state_d = lna_pkg::ST_ERR;
					end else begin
						wr_en = 1'b1;
						len_d = len_q + LEN_W'(1);
					end
				end
			end
			lna_pkg::ST_ERR: begin
				if (slot_free) begin
					load      = 1'b1;
					load_kind = lna_pkg::KIND_ERR;
					load_last = 1'b1;
					state_d   = lna_pkg::ST_IDLE;
				end
			end
			lna_pkg::ST_RD: begin
				rd_en   = 1'b1;
				state_d = lna_pkg::ST_DATA;
			end
			lna_pkg::ST_DATA: begin
				if (slot_free) begin
					load      = 1'b1;
					load_char = rd_data;
					load_last = (rd_q == last_q);
					if (rd_q == last_q) begin
						state_d = lna_pkg::ST_IDLE;
					end else begin
						rd_d    = rd_q + LEN_W'(1);
						state_d = lna_pkg::ST_RD;
					end
				end
			end
			default: state_d = lna_pkg::ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lna_pkg::ST_IDLE;
			len_q   <= '0;
			drop_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			len_q   <= len_d;
			drop_q  <= drop_d;
		end
	end

	// readout counters
	always_ff @(posedge clk) begin
		rd_q   <= rd_d;
		last_q <= last_d;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_cap_q   <= lna_pkg::LINE_CAP_RST;
			reader_cap_q <= lna_pkg::READER_CAP_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == lna_pkg::REG_LINE_CAP) begin
				line_cap_q <= cfg_data;
			end else if (cfg_index == lna_pkg::REG_READER_CAP) begin
				reader_cap_q <= cfg_data;
			end
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (load) begin
			ovalid_q <= 1'b1;
		end else if (m_tready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ochar_q <= load_char;
			okind_q <= load_kind;
			olast_q <= load_last;
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = ochar_q;
	assign m_tuser  = okind_q;
	assign m_tlast  = olast_q;

`ifndef SYNTHESIS
	a_drop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		drop_q |-> (len_q == '0))
		else $error("line length nonzero while dropping");

	a_rd_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lna_pkg::ST_RD || state_q == lna_pkg::ST_DATA) |-> (rd_q <= last_q))
		else $error("readout index past end of line");

	a_wr_idle: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == lna_pkg::ST_IDLE))
		else $error("line store written outside idle");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!ovalid_q || m_tready))
		else $error("pending result word overwritten");

	a_read_then_data: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |=> (state_q == lna_pkg::ST_DATA))
		else $error("store read not followed by data stage");
`endif

endmodule

`default_nettype wire

/* rtl/ascii_line_assembler_core.sv */
// ASCII line assembler top level: sequencer plus line store memory.
// Depends on lna_pkg, lna_ctrl and lna_line_ram.
//
//   channel  | signals                               | word layout
//   s_*      | s_tvalid s_tready s_tdata s_tuser     | tdata rx_byte, tuser opcode
//   m_*      | m_tvalid m_tready m_tdata m_tuser ... | tdata char_out, tuser kind, tlast last
//   cfg_*    | cfg_valid cfg_ready cfg_index cfg_data| index 0 line_capacity, 1 reader_capacity
//
// A byte that produces no result keeps input ready; the next word is taken the cycle after.
// An error result holds the input until its word is loaded. A line streams out in order:
// each character is one store read then an output load. Reset sets both capacities to 64.
// Input is not taken while a line or error result is in progress; output stalls hold
// the readout. Reset also clears length and drop state; the store needs no clearing.
`default_nettype none

module ascii_line_assembler_core #(
	parameter int LINE_DEPTH = lna_pkg::LINE_DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [7:0]                    s_tdata,   // [7:0] rx_byte
	input  wire logic                          s_tuser,   // [0] opcode
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic      [7:0]                    m_tdata,   // [7:0] char_out
	output logic                               m_tuser,   // [0] kind
	output logic                               m_tlast,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [lna_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [lna_pkg::CFG_W-1:0]     cfg_data
);

	localparam int LEN_W = $clog2(LINE_DEPTH);

	logic             wr_en, rd_en;
	logic [LEN_W-1:0] wr_addr, rd_addr;
	logic [7:0]       wr_data, rd_data;

	lna_ctrl #(
		.LINE_DEPTH (LINE_DEPTH),
		.LEN_W      (LEN_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data)
	);

	lna_line_ram #(
		.DEPTH  (LINE_DEPTH),
		.ADDR_W (LEN_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

endmodule

`default_nettype wire
